### hw/rtl/nur_cache_replacement_assert.svh
// Assertion macros used by the checker file.
`ifndef NUR_CACHE_REPLACEMENT_ASSERT_SVH
`define NUR_CACHE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NURC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nurc: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NURC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nurc: assertion failed");

`endif

### hw/rtl/nurc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nurc_pkg;

  // Field widths
  localparam int unsigned LINE_W   = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned COUNT_W  = 32;

  // Default geometry and register reset value
  localparam int unsigned NUM_LINES_DEF = 64;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd16;

  // Configuration port
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam logic REG_IDX_DEREF  = 1'b0;

  // Victim search: lines per encoder group, offset width inside a group
  localparam int unsigned GRP_W     = 32;
  localparam int unsigned GRP_OFF_W = 5;

  // Victim categories in priority order: free line, then classes 0..3
  localparam int unsigned NUM_CAT = 5;
  localparam int unsigned CAT_W   = 3;
  localparam logic [CAT_W-1:0] CAT_FREE = 3'd0;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_VICTIM = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [LINE_W-1:0] line;
    logic              valid_in;
    logic              modified_in;
  } nurc_in_t;

  typedef struct packed {
    logic [LINE_W-1:0]  victim_line;
    logic               victim_was_free;
    logic [CLASS_W-1:0] victim_class;
    logic               refs_cleared;
    logic [COUNT_W-1:0] clear_count;
  } nurc_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the transaction
    logic update;  // apply access, clear or status op and load result
    logic scan;    // register per-group encoder results
    logic pick;    // final victim selection into result
  } nurc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_victim;
  } nurc_stat_t;

endpackage

`default_nettype wire

### hw/rtl/nurc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nurc_ctrl import nurc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  nurc_stat_t stat_i,
  output nurc_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.is_victim) begin
          cmd_o.scan = 1'b1;
          state_d    = ST_PICK;
        end else begin
          cmd_o.update = 1'b1;
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

### hw/rtl/nurc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module nurc_dp import nurc_pkg::*; #(
  parameter int unsigned NUM_LINES = NUM_LINES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nurc_cmd_t           cmd_i,
  output nurc_stat_t          stat_o,
  input  nurc_in_t            item_i,
  input  logic [PERIOD_W-1:0] period_i,
  output nurc_out_t           res_o
);

  localparam int unsigned IDX_W = $clog2(NUM_LINES);
  localparam int unsigned EXT_W = (IDX_W + 1 > LINE_W + 1) ? IDX_W + 1 : LINE_W + 1;
  localparam int unsigned NG    = (NUM_LINES + GRP_W - 1) / GRP_W;
  localparam int unsigned PAD   = NG * GRP_W;
  localparam int unsigned GI_W  = (NG > 1) ? $clog2(NG) : 1;

  nurc_in_t            item_q;
  logic [NUM_LINES-1:0] valid_q, valid_d;
  logic [NUM_LINES-1:0] ref_q, ref_d;
  logic [NUM_LINES-1:0] mod_q, mod_d;
  logic [PERIOD_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0]  clr_q, clr_d;
  nurc_out_t           res_q, res_d;

  logic [EXT_W-1:0] line_ext;
  logic             in_range;
  logic             cleared;

  // Per-group encoder results
  logic [NUM_CAT-1:0]                grp_any_d [NG];
  logic [NUM_CAT-1:0]                grp_any_q [NG];
  logic [NUM_CAT-1:0][GRP_OFF_W-1:0] grp_off_d [NG];
  logic [NUM_CAT-1:0][GRP_OFF_W-1:0] grp_off_q [NG];
  logic [CLASS_W-1:0]                grp_cls_d [NG];
  logic [CLASS_W-1:0]                grp_cls_q [NG];

  logic [PAD-1:0]     inv_p, val_p, ref_p, mod_p;
  logic [PAD-1:0]     cat_m [NUM_CAT];
  logic [NUM_CAT-1:0] cat_any;
  logic [CAT_W-1:0]   sel_cat;
  logic [GI_W-1:0]    sel_g;
  logic [GRP_OFF_W-1:0] sel_off;
  logic [CLASS_W-1:0] sel_cls;

  assign stat_o.is_victim = (item_q.op == OP_VICTIM);

  // Line bookkeeping for access, clear and status ops
  always_comb begin
    valid_d  = valid_q;
    ref_d    = ref_q;
    mod_d    = mod_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    cleared  = 1'b0;
    line_ext = EXT_W'(item_q.line);
    in_range = (line_ext < EXT_W'(NUM_LINES));
    if (cmd_i.update) begin
      unique case (item_q.op)
        OP_ACCESS: begin
          if (in_range) begin
            if (cnt_q >= period_i) begin
              ref_d   = '0;
              cnt_d   = PERIOD_W'(1);
              clr_d   = clr_q + COUNT_W'(1);
              cleared = 1'b1;
            end else begin
              cnt_d = cnt_q + PERIOD_W'(1);
            end
            for (int k = 0; k < NUM_LINES; k++) begin
              if (line_ext == EXT_W'(k)) ref_d[k] = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          ref_d   = '0;
          cnt_d   = '0;
          clr_d   = clr_q + COUNT_W'(1);
          cleared = 1'b1;
        end
        OP_STATUS: begin
          if (in_range) begin
            for (int k = 0; k < NUM_LINES; k++) begin
              if (line_ext == EXT_W'(k)) begin
                valid_d[k] = item_q.valid_in;
                mod_d[k]   = item_q.modified_in;
              end
            end
          end
        end
        OP_VICTIM: begin
          cleared = 1'b0;
        end
        default: begin
          cleared = 1'b0;
        end
      endcase
    end
  end

  // Category masks, padded lines belong to no category
  always_comb begin
    inv_p    = PAD'(~valid_q);
    val_p    = PAD'(valid_q);
    ref_p    = PAD'(ref_q);
    mod_p    = PAD'(mod_q);
    cat_m[0] = inv_p;
    cat_m[1] = val_p & ~ref_p & ~mod_p;
    cat_m[2] = val_p & ~ref_p & mod_p;
    cat_m[3] = val_p & ref_p & ~mod_p;
    cat_m[4] = val_p & ref_p & mod_p;
  end

  // Stage 1: first set line of each category within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_cls_d[g] = '0;
      for (int c = 0; c < NUM_CAT; c++) begin
        grp_any_d[g][c] = |cat_m[c][g*GRP_W +: GRP_W];
        grp_off_d[g][c] = '0;
        for (int j = GRP_W - 1; j >= 0; j--) begin
          if (cat_m[c][g*GRP_W + j]) grp_off_d[g][c] = GRP_OFF_W'(j);
        end
      end
      for (int j = GRP_W - 1; j >= 0; j--) begin
        if (cat_m[0][g*GRP_W + j]) begin
          grp_cls_d[g] = {ref_p[g*GRP_W + j], mod_p[g*GRP_W + j]};
        end
      end
    end
  end

  // Stage 2: lowest category present, then its first group
  always_comb begin
    cat_any = '0;
    for (int g = 0; g < NG; g++) begin
      cat_any = cat_any | grp_any_q[g];
    end
    sel_cat = CAT_FREE;
    for (int c = NUM_CAT - 1; c >= 0; c--) begin
      if (cat_any[c]) sel_cat = CAT_W'(c);
    end
    sel_g   = '0;
    sel_off = '0;
    sel_cls = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g][sel_cat]) begin
        sel_g   = GI_W'(g);
        sel_off = grp_off_q[g][sel_cat];
        sel_cls = grp_cls_q[g];
      end
    end
  end

  // Result word
  always_comb begin
    res_d = res_q;
    if (cmd_i.update) begin
      res_d.victim_line     = '0;
      res_d.victim_was_free = 1'b0;
      res_d.victim_class    = '0;
      res_d.refs_cleared    = cleared;
      res_d.clear_count     = clr_d;
    end else if (cmd_i.pick) begin
      res_d.victim_line     = {sel_g[0], sel_off};
      res_d.victim_was_free = (sel_cat == CAT_FREE);
      res_d.victim_class    = (sel_cat == CAT_FREE) ? sel_cls
                                                    : CLASS_W'(sel_cat - CAT_W'(1));
      res_d.refs_cleared    = 1'b0;
      res_d.clear_count     = clr_q;
    end
  end

  // State flags and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q   <= '0;
      mod_q   <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      mod_q   <= mod_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    res_q <= res_d;
    if (cmd_i.scan) begin
      grp_any_q <= grp_any_d;
      grp_off_q <= grp_off_d;
      grp_cls_q <= grp_cls_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### hw/rtl/nur_cache_replacement.sv
// Channel   Handshake                           Payload
// -------   ---------------------------------   ---------------------------
// command   start in, busy out (take: start &   cmd_i  (nurc_in_t)
//           !busy)
// result    done_o strobe, one cycle            res_o  (nurc_out_t)
// config    APB psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// For access, clear and status ops the accept cycle captures the
// transaction, busy is high for one update cycle, and done_o strobes in the
// cycle after, in which a new command can already be taken.
// In a victim op busy stays high for a registered scan over groups of 32
// lines and then the pick.
// Reset clears all line flags, the access counter and the clearing count;
// deref_period resets to 16. The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module nur_cache_replacement import nurc_pkg::*; #(
  parameter int unsigned NUM_LINES = NUM_LINES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  nurc_in_t          cmd_i,
  // result channel
  output logic              done_o,
  output nurc_out_t         res_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  nurc_cmd_t           cmd;
  nurc_stat_t          stat;
  logic [PERIOD_W-1:0] period_q;
  logic                reg_hit;
  logic                busy_int;

  // Register decode
  assign reg_hit = (paddr[ADDR_W-1] == REG_IDX_DEREF);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? DATA_W'(period_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      period_q <= pwdata[PERIOD_W-1:0];
    end
  end

  nurc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_int),
    .done_o  (done_o)
  );

  nurc_dp #(
    .NUM_LINES (NUM_LINES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .item_i   (cmd_i),
    .period_i (period_q),
    .res_o    (res_o)
  );

  assign busy = busy_int;

endmodule

`default_nettype wire

### hw/rtl/nurc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "nur_cache_replacement_assert.svh"

module nurc_checker import nurc_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done_o,
  input wire nurc_out_t res_o
);

  // A taken transaction keeps the block busy in the next cycle
  `NURC_ASSERT_NEXT(a_take_busy, start && !busy, busy)

  // Results come out only once the block has gone idle
  `NURC_ASSERT_NOW(a_done_idle, done_o, !busy)

  // Strobes never come back to back
  `NURC_ASSERT_NEXT(a_done_single, done_o, !done_o)

  // A clearing op reports no victim
  `NURC_ASSERT_NOW(a_clear_novictim, done_o && res_o.refs_cleared,
                   res_o.victim_line == '0 && !res_o.victim_was_free &&
                   res_o.victim_class == '0)

endmodule

bind nur_cache_replacement nurc_checker u_nurc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire
